/* rtl/core/mrps_pkg.sv */
package mrps_pkg;

  localparam int STRETCH_W  = 32;
  localparam int COEF_W     = 32;
  localparam int RECIP_W    = 57;                 // round(2^56 / s) reaches 2^56 for s = 1
  localparam int RLO_W      = 32;
  localparam int RHI_W      = RECIP_W - RLO_W;
  localparam int PA_W       = STRETCH_W + COEF_W; // c1 * s
  localparam int PB_W       = RECIP_W + COEF_W;   // c2 * r
  localparam int L_SHIFT    = 8;                  // UQ8.24 -> Q.32
  localparam int NUM_W      = 96;                 // exact numerator, signed
  localparam int SCL_W      = 72;                 // numerator after rounding shift
  localparam int QUO_W      = 56;
  localparam int SAT_BIT    = 47;
  localparam int OUT_W      = 48;
  localparam int LANES      = 9;
  localparam int NUM_STRESS = 3;
  localparam int STRESS_SH  = 24;
  localparam int MOD_SH     = 23;
  localparam int STRESS_DIV = 3;
  localparam int MOD_DIV    = 9;

  localparam logic [1:0] SPACE_2D    = 2'd2;
  localparam logic [1:0] SPACE_RESET = 2'd3;

  typedef enum logic [1:0] {
    REG_COEF_FIRST  = 2'd0,
    REG_COEF_SECOND = 2'd1,
    REG_SPACE_DIMS  = 2'd2
  } cfg_reg_e;

  typedef logic [STRETCH_W-1:0] stretch_t;
  typedef logic [COEF_W-1:0]    coef_t;
  typedef logic [RECIP_W-1:0]   recip_t;
  typedef logic [OUT_W-1:0]     res_t;

  typedef struct packed {
    logic valid;
    logic bad;
  } ctl_t;

endpackage

/* rtl/core/mrps_recip.sv */
// Restoring division of 2^56 + s/2 by s, one quotient bit per stage.
module mrps_recip (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  mrps_pkg::ctl_t             ctl_i,
  input  mrps_pkg::stretch_t [2:0]   str_i,
  output mrps_pkg::ctl_t             ctl_o,
  output mrps_pkg::stretch_t [2:0]   str_o,
  output mrps_pkg::recip_t   [2:0]   rcp_o
);

  localparam int Stg  = mrps_pkg::RECIP_W;
  localparam int RemW = mrps_pkg::STRETCH_W;

  mrps_pkg::ctl_t           ctl_q [Stg];
  mrps_pkg::stretch_t [2:0] str_q [Stg];
  logic [2:0][RemW-1:0]     rem_q [Stg];
  mrps_pkg::recip_t   [2:0] quo_q [Stg];

  for (genvar k = 0; k < Stg; k++) begin : g_stg
    localparam int Pos = Stg - 1 - k;

    mrps_pkg::ctl_t           ctl_in;
    mrps_pkg::stretch_t [2:0] str_in;
    logic [2:0][RemW-1:0]     rem_in;
    logic [2:0][RemW-1:0]     rem_d;
    mrps_pkg::recip_t   [2:0] quo_in;
    mrps_pkg::recip_t   [2:0] quo_d;
    logic [2:0]               nbit;

    if (k == 0) begin : g_head
      assign ctl_in = ctl_i;
      assign str_in = str_i;
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_tail
      assign ctl_in = ctl_q[k-1];
      assign str_in = str_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // dividend bit: leading one, then zeros, then the bits of s/2
    if (Pos == Stg - 1) begin : g_lead
      assign nbit = '1;
    end else if (Pos < RemW - 1) begin : g_half
      for (genvar j = 0; j < 3; j++) begin : g_bit
        assign nbit[j] = str_in[j][Pos+1];
      end
    end else begin : g_gap
      assign nbit = '0;
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic [RemW:0] trial;
      logic [RemW:0] diff;
      logic          ge;

      assign trial = {rem_in[j], nbit[j]};
      assign diff  = trial - {1'b0, str_in[j]};
      assign ge    = trial >= {1'b0, str_in[j]};

      always_comb begin
        if (ge) begin
          rem_d[j] = diff[RemW-1:0];
        end else begin
          rem_d[j] = trial[RemW-1:0];
        end
        quo_d[j] = {quo_in[j][Stg-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else if (en_i) begin
        ctl_q[k] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        str_q[k] <= str_in;
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
      end
    end
  end

  assign ctl_o = ctl_q[Stg-1];
  assign str_o = str_q[Stg-1];
  assign rcp_o = quo_q[Stg-1];

endmodule

/* rtl/core/mrps_mul.sv */
// c1 * s and c2 * r; the 57-bit reciprocal is split into two partial products.
module mrps_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  mrps_pkg::coef_t                   coef_first_i,
  input  mrps_pkg::coef_t                   coef_second_i,
  input  mrps_pkg::ctl_t                    ctl_i,
  input  mrps_pkg::stretch_t [2:0]          str_i,
  input  mrps_pkg::recip_t   [2:0]          rcp_i,
  output mrps_pkg::ctl_t                    ctl_o,
  output logic [2:0][mrps_pkg::PA_W-1:0]    pa_o,
  output logic [2:0][mrps_pkg::PB_W-1:0]    pb_o
);

  localparam int PaW   = mrps_pkg::PA_W;
  localparam int PbW   = mrps_pkg::PB_W;
  localparam int RloW  = mrps_pkg::RLO_W;
  localparam int PhiW  = mrps_pkg::COEF_W + mrps_pkg::RHI_W;
  localparam int Depth = 2;

  mrps_pkg::ctl_t       ctl_q [Depth];
  logic [2:0][PaW-1:0]  pa1_q, pa1_d;
  logic [2:0][PaW-1:0]  plo_q, plo_d;
  logic [2:0][PhiW-1:0] phi_q, phi_d;
  logic [2:0][PaW-1:0]  pa2_q;
  logic [2:0][PbW-1:0]  pb_q, pb_d;

  for (genvar j = 0; j < 3; j++) begin : g_lane
    assign pa1_d[j] = PaW'(coef_first_i) * PaW'(str_i[j]);
    assign plo_d[j] = PaW'(coef_second_i) * PaW'(rcp_i[j][RloW-1:0]);
    assign phi_d[j] = PhiW'(coef_second_i) * PhiW'(rcp_i[j][mrps_pkg::RECIP_W-1:RloW]);
    assign pb_d[j]  = {phi_q[j], {RloW{1'b0}}} + PbW'(plo_q[j]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{default: '0};
    end else if (en_i) begin
      ctl_q[0] <= ctl_i;
      ctl_q[1] <= ctl_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa1_q <= pa1_d;
      plo_q <= plo_d;
      phi_q <= phi_d;
      pa2_q <= pa1_q;
      pb_q  <= pb_d;
    end
  end

  assign ctl_o = ctl_q[Depth-1];
  assign pa_o  = pa2_q;
  assign pb_o  = pb_q;

endmodule

/* rtl/core/mrps_comb.sv */
// Linear combinations per output, sum, magnitude, rounding offset and shift.
module mrps_comb (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             en_i,
  input  logic                                             two_d_i,
  input  mrps_pkg::ctl_t                                   ctl_i,
  input  logic [2:0][mrps_pkg::PA_W-1:0]                   pa_i,
  input  logic [2:0][mrps_pkg::PB_W-1:0]                   pb_i,
  output mrps_pkg::ctl_t                                   ctl_o,
  output logic [mrps_pkg::LANES-1:0]                       neg_o,
  output logic [mrps_pkg::LANES-1:0][mrps_pkg::SCL_W-1:0]  scl_o
);

  localparam int NumW    = mrps_pkg::NUM_W;
  localparam int SclW    = mrps_pkg::SCL_W;
  localparam int Lanes   = mrps_pkg::LANES;
  localparam int Depth   = 4;
  localparam int AltLane = mrps_pkg::NUM_STRESS + 2;

  typedef logic signed [3:0] kcoef_t;

  // stresses 0..2, then modulus entries 0..5
  localparam kcoef_t KTab [Lanes][3] = '{
    '{ 4'sd2, -4'sd1, -4'sd1},
    '{-4'sd1,  4'sd2, -4'sd1},
    '{-4'sd1, -4'sd1,  4'sd2},
    '{ 4'sd4,  4'sd1,  4'sd1},
    '{ 4'sd1,  4'sd4,  4'sd1},
    '{ 4'sd1,  4'sd1,  4'sd4},
    '{ 4'sd1, -4'sd2, -4'sd2},
    '{-4'sd2,  4'sd1, -4'sd2},
    '{-4'sd2, -4'sd2,  4'sd1}
  };
  localparam kcoef_t KAlt [3] = '{-4'sd2, -4'sd2, 4'sd1};

  function automatic logic signed [NumW-1:0] lin_comb(
    input logic signed [NumW-1:0] x0,
    input logic signed [NumW-1:0] x1,
    input logic signed [NumW-1:0] x2,
    input kcoef_t                 k0,
    input kcoef_t                 k1,
    input kcoef_t                 k2
  );
    return k0 * x0 + k1 * x1 + k2 * x2;
  endfunction

  function automatic logic sgn_of(input logic signed [NumW-1:0] v);
    return v[NumW-1];
  endfunction

  mrps_pkg::ctl_t         ctl_q [Depth];
  logic signed [NumW-1:0] ax [3];
  logic signed [NumW-1:0] bx [3];
  logic signed [NumW-1:0] ca_q [Lanes];
  logic signed [NumW-1:0] cb_q [Lanes];
  logic signed [NumW-1:0] n_q [Lanes];
  logic [NumW-1:0]        mag_q [Lanes];
  logic [Lanes-1:0]       sgn3_q;
  logic [Lanes-1:0]       sgn4_q;
  logic [SclW-1:0]        scl_q [Lanes];

  for (genvar j = 0; j < 3; j++) begin : g_ext
    assign ax[j] = $signed(NumW'({pa_i[j], {mrps_pkg::L_SHIFT{1'b0}}}));
    assign bx[j] = $signed(NumW'(pb_i[j]));
  end

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    localparam bit IsStress = (l < mrps_pkg::NUM_STRESS);
    localparam int Sh = IsStress ? mrps_pkg::STRESS_SH : mrps_pkg::MOD_SH;
    localparam logic [NumW-1:0] Half = IsStress ?
        (NumW'(mrps_pkg::STRESS_DIV) << (mrps_pkg::STRESS_SH - 1)) :
        (NumW'(mrps_pkg::MOD_DIV) << (mrps_pkg::MOD_SH - 1));

    logic signed [NumW-1:0] ca_d;
    logic signed [NumW-1:0] cb_d;
    logic signed [NumW-1:0] n_d;
    logic [NumW-1:0]        mag_d;
    logic [NumW-1:0]        sum;

    if (l == AltLane) begin : g_alt
      // modulus entry 2 changes form in two-dimension mode
      assign ca_d = two_d_i ?
          lin_comb(ax[0], ax[1], ax[2], KAlt[0], KAlt[1], KAlt[2]) :
          lin_comb(ax[0], ax[1], ax[2], KTab[l][0], KTab[l][1], KTab[l][2]);
      assign cb_d = two_d_i ?
          lin_comb(bx[0], bx[1], bx[2], KAlt[0], KAlt[1], KAlt[2]) :
          lin_comb(bx[0], bx[1], bx[2], KTab[l][0], KTab[l][1], KTab[l][2]);
    end else begin : g_fix
      assign ca_d = lin_comb(ax[0], ax[1], ax[2], KTab[l][0], KTab[l][1], KTab[l][2]);
      assign cb_d = lin_comb(bx[0], bx[1], bx[2], KTab[l][0], KTab[l][1], KTab[l][2]);
    end

    if (IsStress) begin : g_add
      assign n_d = ca_q[l] + cb_q[l];
    end else begin : g_sub
      assign n_d = ca_q[l] - cb_q[l];
    end

    assign mag_d = sgn_of(n_q[l]) ? NumW'(-n_q[l]) : NumW'(n_q[l]);
    assign sum   = mag_q[l] + Half;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ca_q[l]   <= ca_d;
        cb_q[l]   <= cb_d;
        n_q[l]    <= n_d;
        mag_q[l]  <= mag_d;
        sgn3_q[l] <= sgn_of(n_q[l]);
        sgn4_q[l] <= sgn3_q[l];
        scl_q[l]  <= sum[Sh +: SclW];
      end
    end

    assign scl_o[l] = scl_q[l];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{default: '0};
    end else if (en_i) begin
      ctl_q[0] <= ctl_i;
      for (int s = 1; s < Depth; s++) begin
        ctl_q[s] <= ctl_q[s-1];
      end
    end
  end

  assign ctl_o = ctl_q[Depth-1];
  assign neg_o = sgn4_q;

endmodule

/* rtl/core/mrps_cdiv.sv */
// Divide by 3 or 9 through a rounded-up reciprocal multiply, then saturate and sign.
module mrps_cdiv (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             en_i,
  input  logic                                             two_d_i,
  input  mrps_pkg::ctl_t                                   ctl_i,
  input  logic [mrps_pkg::LANES-1:0]                       neg_i,
  input  logic [mrps_pkg::LANES-1:0][mrps_pkg::SCL_W-1:0]  scl_i,
  output mrps_pkg::ctl_t                                   ctl_o,
  output mrps_pkg::res_t [mrps_pkg::LANES-1:0]             res_o
);

  localparam int SclW  = mrps_pkg::SCL_W;
  localparam int OutW  = mrps_pkg::OUT_W;
  localparam int Lanes = mrps_pkg::LANES;
  localparam int XW    = 51;              // below 9 * 2^47 once saturation is ruled out
  localparam int LoW   = 32;
  localparam int XhW   = XW - LoW;
  localparam int RcpW  = 52;
  localparam int RhW   = RcpW - LoW;
  localparam int MidW  = LoW + RhW + 1;
  localparam int ProdW = XW + RcpW + 1;
  localparam int Depth = 5;
  localparam int Stg   = Depth - 1;
  localparam logic [OutW-1:0] MagMax = OutW'(1) << mrps_pkg::SAT_BIT;
  localparam logic [OutW-1:0] PosMax = MagMax - OutW'(1);

  mrps_pkg::ctl_t ctl_q [Depth];

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    localparam bit IsStress = (l < mrps_pkg::NUM_STRESS);
    localparam logic [SclW-1:0] Dv = IsStress ? SclW'(mrps_pkg::STRESS_DIV) :
                                                SclW'(mrps_pkg::MOD_DIV);
    // quotient exact while x * (ceil(2^Kd / d) * d - 2^Kd) < 2^Kd
    localparam int Kd = IsStress ? 53 : 55;
    localparam logic [63:0] RcpFull = ((64'd1 << Kd) + 64'(Dv) - 64'd1) / 64'(Dv);
    localparam logic [RcpW-1:0] Rcp = RcpFull[RcpW-1:0];
    localparam bit Zero2d = (l == mrps_pkg::NUM_STRESS - 1) || (l >= Lanes - 3);

    logic [XW-1:0]          x_q;
    logic                   sat_q [Stg];
    logic                   neg_q [Stg];
    logic [2*LoW-1:0]       pll_d, pll_q, pll2_q;
    logic [LoW+RhW-1:0]     plh_d, plh_q;
    logic [XhW+LoW-1:0]     phl_d, phl_q;
    logic [XhW+RhW-1:0]     phh_d, phh_q, phh2_q;
    logic [MidW-1:0]        mid_d, mid_q;
    logic [ProdW-1:0]       prod;
    logic [OutW-1:0]        quo_q;
    logic [OutW-1:0]        mag;
    mrps_pkg::res_t         res_d;
    mrps_pkg::res_t         res_q;

    assign pll_d = (2*LoW)'(x_q[LoW-1:0]) * (2*LoW)'(Rcp[LoW-1:0]);
    assign plh_d = (LoW+RhW)'(x_q[LoW-1:0]) * (LoW+RhW)'(Rcp[RcpW-1:LoW]);
    assign phl_d = (XhW+LoW)'(x_q[XW-1:LoW]) * (XhW+LoW)'(Rcp[LoW-1:0]);
    assign phh_d = (XhW+RhW)'(x_q[XW-1:LoW]) * (XhW+RhW)'(Rcp[RcpW-1:LoW]);
    assign mid_d = MidW'(plh_q) + MidW'(phl_q);
    assign prod  = (ProdW'(phh2_q) << (2*LoW)) + (ProdW'(mid_q) << LoW) + ProdW'(pll2_q);

    always_comb begin
      if (sat_q[Stg-1]) begin
        mag = MagMax;
      end else begin
        mag = quo_q;
      end
      if (ctl_q[Stg-1].bad || (Zero2d && two_d_i)) begin
        res_d = '0;
      end else if (neg_q[Stg-1]) begin
        res_d = OutW'(0) - mag;
      end else if (sat_q[Stg-1]) begin
        res_d = PosMax;
      end else begin
        res_d = mag;
      end
    end

    // stage 0: overflow check; below d * 2^47 the value fits the multiplier
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q      <= scl_i[l][XW-1:0];
        sat_q[0] <= scl_i[l] >= (Dv << mrps_pkg::SAT_BIT);
        neg_q[0] <= neg_i[l];
        for (int s = 1; s < Stg; s++) begin
          sat_q[s] <= sat_q[s-1];
          neg_q[s] <= neg_q[s-1];
        end
        pll_q  <= pll_d;
        plh_q  <= plh_d;
        phl_q  <= phl_d;
        phh_q  <= phh_d;
        pll2_q <= pll_q;
        mid_q  <= mid_d;
        phh2_q <= phh_q;
        quo_q  <= prod[Kd +: OutW];
        res_q  <= res_d;
      end
    end

    assign res_o[l] = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{default: '0};
    end else if (en_i) begin
      ctl_q[0] <= ctl_i;
      for (int s = 1; s < Depth; s++) begin
        ctl_q[s] <= ctl_q[s-1];
      end
    end
  end

  assign ctl_o = ctl_q[Depth-1];

endmodule

/* rtl/core/mooney_rivlin_principal_stress_unit.sv */
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata: stretch_a, stretch_b, stretch_c
// m_axis    out  m_axis_tvalid/tready       tdata: stresses, modulus entries; tuser: bad flag
// cfg       in   cfg_valid_i/cfg_ready_o    cfg_addr_i register index, cfg_data_i value
//
// One item per cycle while no stall holds the pipeline; 69 register stages: the 57-stage
// reciprocal divider, two multiply stages, four add stages, five stages of constant
// division by reciprocal multiply and saturation, and the output register.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// A stall freezes the whole pipeline; a one-entry skid register keeps tready registered.
module mooney_rivlin_principal_stress_unit (
  input  logic         clk_i,
  input  logic         rst_ni,

  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // stretch_a, stretch_b, stretch_c

  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [431:0] m_axis_tdata,   // stress_a..c, modulus_a..f
  output logic [0:0]   m_axis_tuser,   // bad_stretch

  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_addr_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int Lanes = mrps_pkg::LANES;

  mrps_pkg::coef_t coef_first_q;
  mrps_pkg::coef_t coef_second_q;
  logic [1:0]      space_dims_q;
  logic            two_d;
  logic            en;

  mrps_pkg::stretch_t [2:0] str_in;
  mrps_pkg::ctl_t           ctl_in;

  mrps_pkg::ctl_t                         rcp_ctl;
  mrps_pkg::stretch_t [2:0]               rcp_str;
  mrps_pkg::recip_t   [2:0]               rcp_val;
  mrps_pkg::ctl_t                         mul_ctl;
  logic [2:0][mrps_pkg::PA_W-1:0]         mul_pa;
  logic [2:0][mrps_pkg::PB_W-1:0]         mul_pb;
  mrps_pkg::ctl_t                         cmb_ctl;
  logic [Lanes-1:0]                       cmb_neg;
  logic [Lanes-1:0][mrps_pkg::SCL_W-1:0]  cmb_scl;
  mrps_pkg::ctl_t                         div_ctl;
  mrps_pkg::res_t [Lanes-1:0]             div_res;

  logic                       out_v_q, out_v_d;
  logic                       skid_v_q, skid_v_d;
  mrps_pkg::res_t [Lanes-1:0] out_res_q, skid_res_q;
  logic                       out_bad_q, skid_bad_q;
  logic                       out_load, out_from_skid, skid_load;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_first_q  <= '0;
      coef_second_q <= '0;
      space_dims_q  <= mrps_pkg::SPACE_RESET;
    end else if (cfg_valid_i) begin
      case (mrps_pkg::cfg_reg_e'(cfg_addr_i))
        mrps_pkg::REG_COEF_FIRST:  coef_first_q  <= cfg_data_i;
        mrps_pkg::REG_COEF_SECOND: coef_second_q <= cfg_data_i;
        mrps_pkg::REG_SPACE_DIMS:  space_dims_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign two_d = (space_dims_q == mrps_pkg::SPACE_2D);

  // pipeline advances whenever the skid entry is free
  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  assign str_in       = s_axis_tdata;
  assign ctl_in.valid = s_axis_tvalid;
  assign ctl_in.bad   = (str_in[0] == '0) || (str_in[1] == '0) || (str_in[2] == '0);

  mrps_recip u_recip (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (ctl_in),
    .str_i  (str_in),
    .ctl_o  (rcp_ctl),
    .str_o  (rcp_str),
    .rcp_o  (rcp_val)
  );

  mrps_mul u_mul (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .coef_first_i  (coef_first_q),
    .coef_second_i (coef_second_q),
    .ctl_i         (rcp_ctl),
    .str_i         (rcp_str),
    .rcp_i         (rcp_val),
    .ctl_o         (mul_ctl),
    .pa_o          (mul_pa),
    .pb_o          (mul_pb)
  );

  mrps_comb u_comb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .two_d_i (two_d),
    .ctl_i   (mul_ctl),
    .pa_i    (mul_pa),
    .pb_i    (mul_pb),
    .ctl_o   (cmb_ctl),
    .neg_o   (cmb_neg),
    .scl_o   (cmb_scl)
  );

  mrps_cdiv u_cdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .two_d_i (two_d),
    .ctl_i   (cmb_ctl),
    .neg_i   (cmb_neg),
    .scl_i   (cmb_scl),
    .ctl_o   (div_ctl),
    .res_o   (div_res)
  );

  // output register with one skid entry
  always_comb begin
    out_v_d       = out_v_q;
    skid_v_d      = skid_v_q;
    out_load      = 1'b0;
    out_from_skid = 1'b0;
    skid_load     = 1'b0;
    if (!out_v_q || m_axis_tready) begin
      if (skid_v_q) begin
        out_v_d       = 1'b1;
        skid_v_d      = 1'b0;
        out_load      = 1'b1;
        out_from_skid = 1'b1;
      end else begin
        out_v_d  = div_ctl.valid;
        out_load = div_ctl.valid;
      end
    end else if (div_ctl.valid && !skid_v_q) begin
      skid_v_d  = 1'b1;
      skid_load = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q <= out_from_skid ? skid_res_q : div_res;
      out_bad_q <= out_from_skid ? skid_bad_q : div_ctl.bad;
    end
    if (skid_load) begin
      skid_res_q <= div_res;
      skid_bad_q <= div_ctl.bad;
    end
  end

  assign m_axis_tvalid   = out_v_q;
  assign m_axis_tdata    = out_res_q;
  assign m_axis_tuser[0] = out_bad_q;

endmodule
